/* rtl/core/i32alu_pkg.sv */
package i32alu_pkg;

    localparam int DataW = 32;
    localparam int QueueDepthDefault = 2;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,
        OP_OR   = 5'd5,
        OP_XOR  = 5'd6,
        OP_AND  = 5'd7,
        OP_LSH  = 5'd8,
        OP_RSH  = 5'd9,
        OP_URSH = 5'd10,
        OP_NOT  = 5'd11,
        OP_NEG  = 5'd12,
        OP_LT   = 5'd13,
        OP_LE   = 5'd14,
        OP_GT   = 5'd15,
        OP_GE   = 5'd16,
        OP_EQ   = 5'd17,
        OP_NE   = 5'd18
    } op_t;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_DBL  = 2'd2;

    // classified beat handed from front to back
    typedef struct packed {
        logic              early_fail;
        logic [4:0]        op;
        logic [DataW-1:0]  a;
        logic [DataW-1:0]  b;
    } work_t;

endpackage

/* rtl/core/i32alu_front.sv */
module i32alu_front (
    input  logic                  req_valid,
    input  logic [4:0]            req_type,
    input  logic signed [31:0]    lhs,
    input  logic signed [31:0]    rhs,
    input  logic                  lhs_is_int,
    input  logic                  rhs_is_int,
    output i32alu_pkg::work_t     work
);

    logic unary;

    // classify: tag checks and undefined codes fail up front
    always_comb
    begin
        unary = (req_type == i32alu_pkg::OP_NOT) || (req_type == i32alu_pkg::OP_NEG);
        work.early_fail = !lhs_is_int || (!unary && !rhs_is_int)
                          || (req_type > i32alu_pkg::OP_NE) || !req_valid;
        work.op = req_type;
        work.a  = lhs;
        work.b  = rhs;
    end

endmodule

/* rtl/core/i32alu_queue.sv */
module i32alu_queue #(
    parameter int Depth = i32alu_pkg::QueueDepthDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  i32alu_pkg::work_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output i32alu_pkg::work_t  out_data
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    i32alu_pkg::work_t  mem_reg [Depth];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               push, pop;

    always_comb
    begin
        in_ready  = (count_reg != (AW+1)'(Depth)) || out_ready;
        out_valid = (count_reg != '0);
        out_data  = mem_reg[rd_ptr_reg];
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
    end

    // store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

/* rtl/core/i32alu_div.sv */
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module i32alu_div (
    input  logic         clk,
    input  logic         en,
    input  logic [31:0]  dividend,
    input  logic [31:0]  divisor,
    output logic [31:0]  quot,
    output logic [31:0]  rem
);

    logic [31:0] q_in    [32];
    logic [31:0] r_in    [32];
    logic [31:0] d_in    [32];
    logic [31:0] q_reg   [32];
    logic [31:0] r_reg   [32];
    logic [31:0] d_reg   [31];
    logic [32:0] trial   [32];
    logic [32:0] shifted [32];

    for (genvar s = 0; s < 32; s++)
    begin : g_stage
        // take operands from the issue side or the previous stage
        if (s == 0)
        begin : g_first
            assign q_in[s] = dividend;
            assign r_in[s] = '0;
            assign d_in[s] = divisor;
        end
        else
        begin : g_next
            assign q_in[s] = q_reg[s-1];
            assign r_in[s] = r_reg[s-1];
            assign d_in[s] = d_reg[s-1];
        end

        assign shifted[s] = {r_in[s], q_in[s][31]};
        assign trial[s]   = shifted[s] - {1'b0, d_in[s]};

        // advance one quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!trial[s][32])
                begin
                    r_reg[s] <= trial[s][31:0];
                    q_reg[s] <= {q_in[s][30:0], 1'b1};
                end
                else
                begin
                    r_reg[s] <= shifted[s][31:0];
                    q_reg[s] <= {q_in[s][30:0], 1'b0};
                end
            end
        end

        // carry the divisor to the next stage
        if (s < 31)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[s] <= d_in[s];
                end
            end
        end
    end

    assign quot = q_reg[31];
    assign rem  = r_reg[31];

endmodule

/* rtl/core/i32alu_back.sv */
// Execute pipeline: 32 stages alongside the divider, then an output register.
module i32alu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  allow_double_result,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i32alu_pkg::work_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  fail,
    output logic [1:0]            result_kind,
    output logic signed [32:0]    value
);

    localparam int Lat = 32;

    // all stages advance together and hold while the output waits
    logic              vld_reg [Lat];
    i32alu_pkg::work_t w_reg   [Lat];
    logic [63:0]       prod_reg [Lat];
    logic [35:0]       simple_reg [Lat]; // {fail, kind, value}
    logic              adv;
    logic              out_full_reg;
    logic              res_fail_reg;
    logic [1:0]        res_kind_reg;
    logic [32:0]       res_val_reg;

    logic [31:0]       a_mag, b_mag, quot, rem;
    logic signed [31:0] sa, sb;
    logic [4:0]        sh;
    logic [31:0]       us;
    logic              sfail;
    logic [1:0]        skind;
    logic [32:0]       sval;
    logic signed [32:0] sum;
    logic signed [63:0] prod;

    assign adv      = !out_full_reg || out_ready;
    assign in_ready = adv;

    // simple ops resolve at issue
    always_comb
    begin
        sa = in_data.a;
        sb = in_data.b;
        sh = in_data.b[4:0];
        us = in_data.a >> sh;
        a_mag = sa[31] ? 32'(-sa) : in_data.a;
        b_mag = sb[31] ? 32'(-sb) : in_data.b;
        prod  = sa * sb;
        sfail = 1'b0;
        skind = i32alu_pkg::KIND_INT;
        sval  = '0;
        sum   = '0;
        unique case (in_data.op)
            i32alu_pkg::OP_ADD:
            begin
                sum = 33'(sa) + 33'(sb);
                sfail = sum[32] != sum[31];
                sval = sum;
            end
            i32alu_pkg::OP_SUB:
            begin
                sum = 33'(sa) - 33'(sb);
                sfail = sum[32] != sum[31];
                sval = sum;
            end
            i32alu_pkg::OP_OR:  sval = 33'(signed'(sa | sb));
            i32alu_pkg::OP_XOR: sval = 33'(signed'(sa ^ sb));
            i32alu_pkg::OP_AND: sval = 33'(signed'(sa & sb));
            i32alu_pkg::OP_LSH: sval = 33'(signed'(sa << sh));
            i32alu_pkg::OP_RSH: sval = 33'(sa >>> sh);
            i32alu_pkg::OP_URSH:
            begin
                if (us[31])
                begin
                    sfail = !allow_double_result;
                    skind = i32alu_pkg::KIND_DBL;
                end
                sval = {1'b0, us};
            end
            i32alu_pkg::OP_NOT: sval = 33'(signed'(~sa));
            i32alu_pkg::OP_NEG:
            begin
                sfail = in_data.a[30:0] == '0;
                sval = -33'(sa);
            end
            i32alu_pkg::OP_LT: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa <  sb); end
            i32alu_pkg::OP_LE: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa <= sb); end
            i32alu_pkg::OP_GT: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa >  sb); end
            i32alu_pkg::OP_GE: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa >= sb); end
            i32alu_pkg::OP_EQ: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa == sb); end
            i32alu_pkg::OP_NE: begin skind = i32alu_pkg::KIND_BOOL; sval = 33'(sa != sb); end
            default: sfail = 1'b0;
        endcase
    end

    i32alu_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (a_mag),
        .divisor  (b_mag),
        .quot     (quot),
        .rem      (rem)
    );

    // stage 0 takes the beat, product registered here
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0]      <= in_data;
            prod_reg[0]   <= prod;
            simple_reg[0] <= {sfail, skind, sval};
            for (int i = 1; i < Lat; i++)
            begin
                w_reg[i]      <= w_reg[i-1];
                prod_reg[i]   <= prod_reg[i-1];
                simple_reg[i] <= simple_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < Lat; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // finish: guards on mul/div/mod at the last stage
    logic               f_fail;
    logic [1:0]         f_kind;
    logic [32:0]        f_val;
    logic signed [31:0] fa, fb;
    logic [63:0]        p;
    logic [31:0]        q_s, r_s;
    i32alu_pkg::work_t  fw;

    always_comb
    begin
        fw  = w_reg[Lat-1];
        fa  = fw.a;
        fb  = fw.b;
        p   = prod_reg[Lat-1];
        q_s = (fa[31] ^ fb[31]) ? 32'(-quot) : quot;
        r_s = fa[31] ? 32'(-rem) : rem;
        {f_fail, f_kind, f_val} = simple_reg[Lat-1];
        unique case (fw.op)
            i32alu_pkg::OP_MUL:
            begin
                f_kind = i32alu_pkg::KIND_INT;
                f_fail = (p[63:31] != '0 && p[63:31] != '1)
                         || (p == '0 && (fa[31] || fb[31]));
                f_val  = p[32:0];
            end
            i32alu_pkg::OP_DIV:
            begin
                f_kind = i32alu_pkg::KIND_INT;
                f_fail = (fw.b == '0) || (fw.a == 32'h8000_0000)
                         || (fw.a == '0 && fb[31]) || (rem != '0);
                f_val  = 33'(signed'(q_s));
            end
            i32alu_pkg::OP_MOD:
            begin
                f_kind = i32alu_pkg::KIND_INT;
                f_fail = (fw.b == '0) || (fw.a[30:0] == '0)
                         || (rem == '0 && (q_s[31] || fb[31]));
                f_val  = 33'(signed'(r_s));
            end
            default: f_fail = f_fail;
        endcase
        if (fw.early_fail)
        begin
            f_fail = 1'b1;
        end
        if (f_fail)
        begin
            f_kind = i32alu_pkg::KIND_INT;
            f_val  = '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_full_reg <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_fail_reg <= f_fail;
            res_kind_reg <= f_kind;
            res_val_reg  <= f_val;
        end
    end

    assign out_valid   = out_full_reg;
    assign fail        = res_fail_reg;
    assign result_kind = res_kind_reg;
    assign value       = res_val_reg;

endmodule

/* rtl/core/int32_alu_with_guard_failure.sv */
// Int32 fast-path ALU with guard failure. One request beat in, one result
// beat out, in order; a new beat is taken every cycle while the back pipeline
// is not stalled. A request passes through the two-entry queue behind the
// combinational front classifier, the stages of the radix-2 divider pipeline
// that every operation follows, and the output register. The back
// pipeline stalls as a whole only while a result waits to be taken.
module int32_alu_with_guard_failure #(
    parameter int QueueDepth = i32alu_pkg::QueueDepthDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [4:0]          req_type,
    input  logic signed [31:0]  lhs,
    input  logic signed [31:0]  rhs,
    input  logic                lhs_is_int,
    input  logic                rhs_is_int,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                fail,
    output logic [1:0]          result_kind,
    output logic signed [32:0]  value
);

    logic              allow_double_reg;
    i32alu_pkg::work_t fw, qw;
    logic              q_valid, q_ready;

    // hold the config bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_double_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            allow_double_reg <= cfg_wdata;
        end
    end

    i32alu_front u_front (
        .req_valid  (in_valid),
        .req_type   (req_type),
        .lhs        (lhs),
        .rhs        (rhs),
        .lhs_is_int (lhs_is_int),
        .rhs_is_int (rhs_is_int),
        .work       (fw)
    );

    i32alu_queue #(.Depth(QueueDepth)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (fw),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (qw)
    );

    i32alu_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .allow_double_result (allow_double_reg),
        .in_valid            (q_valid),
        .in_ready            (q_ready),
        .in_data             (qw),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .fail                (fail),
        .result_kind         (result_kind),
        .value               (value)
    );

endmodule

/* bench/int32_alu_with_guard_failure_chk.sv */
`timescale 1ns / 1ps

module int32_alu_with_guard_failure_chk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [4:0]          req_type,
    input  logic signed [31:0]  lhs,
    input  logic signed [31:0]  rhs,
    input  logic                lhs_is_int,
    input  logic                rhs_is_int,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                fail,
    input  logic [1:0]          result_kind,
    input  logic signed [32:0]  value,
    output int                  err_count,
    output int                  pending,
    output int                  result_count
);

    typedef struct packed {
        logic              fail;
        logic [1:0]        kind;
        logic signed [32:0] value;
    } alu_result_t;

    alu_result_t result_q[$];
    logic        dbl_ok;

    // compute the fast-path result of one request
    function automatic alu_result_t alu_predict(logic [4:0] op, logic [31:0] ua,
                                                logic [31:0] ub, logic ta, logic tb,
                                                logic dbl);
        alu_result_t res;
        longint a, b, r, q;
        logic [31:0] s;
        logic unary;
        logic bad;
        logic [4:0] sh;
        a = longint'($signed(ua));
        b = longint'($signed(ub));
        sh = ub[4:0];
        unary = (op == i32alu_pkg::OP_NOT) || (op == i32alu_pkg::OP_NEG);
        bad = 1'b0;
        r = 0;
        res = '0;
        if (!ta || (!unary && !tb) || op > i32alu_pkg::OP_NE)
            bad = 1'b1;
        else
        begin
            case (op)
                i32alu_pkg::OP_ADD:
                begin
                    r = a + b;
                    bad = r > 64'sd2147483647 || r < -64'sd2147483648;
                end
                i32alu_pkg::OP_SUB:
                begin
                    r = a - b;
                    bad = r > 64'sd2147483647 || r < -64'sd2147483648;
                end
                i32alu_pkg::OP_MUL:
                begin
                    r = a * b;
                    bad = r > 64'sd2147483647 || r < -64'sd2147483648 ||
                          (r == 0 && (a < 0 || b < 0));
                end
                i32alu_pkg::OP_DIV:
                begin
                    if (b == 0 || a == -64'sd2147483648 || (a == 0 && b < 0))
                        bad = 1'b1;
                    else
                    begin
                        r = a / b;
                        bad = (a % b) != 0;
                    end
                end
                i32alu_pkg::OP_MOD:
                begin
                    if (b == 0 || ua[30:0] == '0)
                        bad = 1'b1;
                    else
                    begin
                        q = a / b;
                        r = a % b;
                        bad = r == 0 && (q < 0 || b < 0);
                    end
                end
                i32alu_pkg::OP_OR:  r = longint'($signed(ua | ub));
                i32alu_pkg::OP_XOR: r = longint'($signed(ua ^ ub));
                i32alu_pkg::OP_AND: r = longint'($signed(ua & ub));
                i32alu_pkg::OP_LSH: r = longint'($signed(ua << sh));
                i32alu_pkg::OP_RSH: r = longint'($signed(ua) >>> sh);
                i32alu_pkg::OP_URSH:
                begin
                    s = ua >> sh;
                    if (s[31])
                    begin
                        if (dbl)
                        begin
                            res.kind = i32alu_pkg::KIND_DBL;
                            r = longint'(s);
                        end
                        else
                            bad = 1'b1;
                    end
                    else
                        r = longint'(s);
                end
                i32alu_pkg::OP_NOT: r = longint'($signed(~ua));
                i32alu_pkg::OP_NEG:
                begin
                    if (ua[30:0] == '0)
                        bad = 1'b1;
                    else
                        r = -a;
                end
                default:
                begin
                    res.kind = i32alu_pkg::KIND_BOOL;
                    case (op)
                        i32alu_pkg::OP_LT: r = a < b;
                        i32alu_pkg::OP_LE: r = a <= b;
                        i32alu_pkg::OP_GT: r = a > b;
                        i32alu_pkg::OP_GE: r = a >= b;
                        i32alu_pkg::OP_EQ: r = a == b;
                        default:           r = a != b;
                    endcase
                end
            endcase
        end
        if (bad)
            res = '{fail: 1'b1, kind: i32alu_pkg::KIND_INT, value: '0};
        else
            res.value = r[32:0];
        return res;
    endfunction

    assign pending = result_q.size();

    // track the register, queue expectations, compare results
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t got;
        alu_result_t want;
        if (!rst_n)
        begin
            dbl_ok       <= 1'b0;
            err_count    <= 0;
            result_count <= 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_we)
                dbl_ok <= cfg_wdata;
            if (in_valid && in_ready)
                result_q.push_back(alu_predict(req_type, lhs, rhs, lhs_is_int,
                                               rhs_is_int, dbl_ok));
            if (out_valid && out_ready)
            begin
                got = '{fail: fail, kind: result_kind, value: value};
                result_count <= result_count + 1;
                if (result_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %p", $time, got);
                    err_count <= err_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.fail !== want.fail || got.kind !== want.kind ||
                        got.value !== want.value)
                    begin
                        $display("%0t: mismatch expected fail=%0b kind=%0d value=%0d",
                                 $time, want.fail, want.kind, want.value);
                        $display("%0t:          actual   fail=%0b kind=%0d value=%0d",
                                 $time, got.fail, got.kind, got.value);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/int32_alu_with_guard_failure_tb.sv */
`timescale 1ns / 1ps

module int32_alu_with_guard_failure_tb;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [4:0]         req_type;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic               lhs_is_int;
    logic               rhs_is_int;
    logic               out_valid;
    logic               out_ready;
    logic               fail;
    logic [1:0]         result_kind;
    logic signed [32:0] value;
    int                 err_count;
    int                 pending;
    int                 result_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 recv_hold;
    int                 hold_req;
    int                 hold_ack;
    int                 beat_count;

    localparam logic signed [31:0] MinInt = 32'sh8000_0000;
    localparam logic signed [31:0] MaxInt = 32'sh7fff_ffff;
    localparam logic [4:0]         OpUndef = 5'd31;

    int32_alu_with_guard_failure dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .lhs(lhs), .rhs(rhs), .lhs_is_int(lhs_is_int), .rhs_is_int(rhs_is_int),
        .out_valid(out_valid), .out_ready(out_ready), .fail(fail),
        .result_kind(result_kind), .value(value)
    );

    int32_alu_with_guard_failure_chk chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .lhs(lhs), .rhs(rhs), .lhs_is_int(lhs_is_int), .rhs_is_int(rhs_is_int),
        .out_valid(out_valid), .out_ready(out_ready), .fail(fail),
        .result_kind(result_kind), .value(value), .err_count(err_count),
        .pending(pending), .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hold off the run if it hangs
    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("[int32_alu_with_guard_failure] ERROR");
        $finish;
    end

    // receiver: random stalls, plus a long hold when asked
    initial
    begin
        out_ready = 1'b0;
        recv_hold = 0;
        hold_ack  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                recv_hold = 300;
            end
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                recv_hold = recv_hold - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one beat and wait for its acceptance
    task automatic send_beat(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                             logic ta, logic tb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        lhs        <= a;
        rhs        <= b;
        lhs_is_int <= ta;
        rhs_is_int <= tb;
        do
            @(posedge clk);
        while (!in_ready);
        beat_count++;
    endtask

    // drain all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return MinInt;
            1: return MaxInt;
            2: return 32'd0;
            3: return $urandom_range(8) - 4;
            4: return $urandom_range(200) - 100;
            5: return -($urandom_range(65535));
            6: return $urandom_range(65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random();
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic        ta;
        logic        tb;
        op = ($urandom_range(29) == 0) ? 5'($urandom_range(31, 19))
                                       : 5'($urandom_range(i32alu_pkg::OP_NE));
        a  = pick_operand();
        b  = pick_operand();
        // make exact quotients common for divide and modulo
        if ((op == i32alu_pkg::OP_DIV || op == i32alu_pkg::OP_MOD)
            && $urandom_range(1) && b != 0)
            a = 32'($signed(b) * ($signed(32'($urandom_range(2000))) - 1000));
        ta = ($urandom_range(19) != 0);
        tb = ($urandom_range(19) != 0);
        send_beat(op, a, b, ta, tb);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        in_valid      = 1'b0;
        req_type      = i32alu_pkg::OP_ADD;
        lhs           = '0;
        rhs           = '0;
        lhs_is_int    = 1'b0;
        rhs_is_int    = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 71;
        hold_req      = 0;
        beat_count    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners with doubles disabled
        write_cfg(1'b0);
        send_beat(i32alu_pkg::OP_ADD, MaxInt, 32'd1, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_SUB, MinInt, 32'd1, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_MUL, 32'd0, -32'sd5, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_MUL, 32'h10000, 32'h10000, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_DIV, 32'd7, 32'd0, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_DIV, MinInt, -32'sd1, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_DIV, 32'd0, -32'sd3, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_DIV, 32'd7, 32'd2, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_DIV, -32'sd8, 32'd2, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_MOD, 32'd0, 32'd3, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_MOD, -32'sd6, 32'd3, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_MOD, -32'sd7, 32'd3, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_OR, MinInt, MaxInt, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_XOR, 32'hffff_ffff, 32'h5555_5555, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_AND, 32'hffff_ffff, 32'h5555_5555, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_LSH, 32'd1, 32'd63, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_RSH, MinInt, 32'd31, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_URSH, -32'sd1, 32'd0, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_NOT, 32'd0, 32'd0, 1'b1, 1'b0);
        send_beat(i32alu_pkg::OP_NEG, MinInt, 32'd0, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_NEG, 32'd0, 32'd0, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_LT, 32'd1, 32'd2, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_EQ, 32'd2, 32'd2, 1'b0, 1'b1);
        send_beat(OpUndef, 32'd2, 32'd2, 1'b1, 1'b1);
        drain();

        // doubles allowed for unsigned shift
        write_cfg(1'b1);
        send_beat(i32alu_pkg::OP_URSH, -32'sd1, 32'd0, 1'b1, 1'b1);
        send_beat(i32alu_pkg::OP_URSH, MinInt, 32'd32, 1'b1, 1'b1);
        repeat (500) send_random();

        // long receiver hold while the sender keeps offering
        hold_req++;
        repeat (100) send_random();
        drain();

        send_idle_pct = 71;
        recv_idle_pct = 6;
        write_cfg(1'b0);
        repeat (450) send_random();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(1'b1);
        repeat (480) send_random();
        drain();

        $display("sent %0d request beats over both register settings, %0d results checked",
                 beat_count, result_count);
        if (err_count == 0)
            $display("[int32_alu_with_guard_failure] OK");
        else
            $display("[int32_alu_with_guard_failure] ERROR");
        $finish;
    end

endmodule
